FILE: rtl/grs_pkg.sv
// Shared types and constants for the gray region statistics block.
`timescale 1ns / 1ps
`default_nettype none
package grs_pkg;

    localparam int LABEL_W = 10;
    localparam int GRAY_W  = 8;
    localparam int COORD_W = 10;
    localparam int CNT_W   = 21;
    localparam int GSUM_W  = 28;
    localparam int GSQ_W   = 36;
    localparam int CSUM_W  = 30;
    localparam int CSQ_W   = 40;

    localparam int MEANG_W = 16;
    localparam int STDG_W  = 15;
    localparam int MEANC_W = 14;
    localparam int STDC_W  = 13;

    localparam int MEAN_MAX_GRAY  = 65280;
    localparam int STD_MAX_GRAY   = 32640;
    localparam int MEAN_MAX_COORD = 16368;
    localparam int STD_MAX_COORD  = 8184;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // One classified item as it travels from the front to the store
    typedef struct packed {
        logic                   is_read;
        logic                   oor;
        logic [LABEL_W-1:0]     label;
        logic [GRAY_W-1:0]      gray;
        logic [2*GRAY_W-1:0]    gray_sq;
        logic [COORD_W-1:0]     row;
        logic [2*COORD_W-1:0]   row_sq;
        logic [COORD_W-1:0]     col;
        logic [2*COORD_W-1:0]   col_sq;
    } t_op;

    // One segment's accumulators
    typedef struct packed {
        logic [GSUM_W-1:0] gray_sum;
        logic [GSQ_W-1:0]  gray_sq_sum;
        logic [CSUM_W-1:0] row_sum;
        logic [CSUM_W-1:0] col_sum;
        logic [CSQ_W-1:0]  row_sq_sum;
        logic [CSQ_W-1:0]  col_sq_sum;
        logic [CNT_W-1:0]  count;
    } t_entry;

    // Read-out job handed to the moments unit
    typedef struct packed {
        logic               oor;
        logic [LABEL_W-1:0] label;
        t_entry             ent;
    } t_job;

endpackage
`default_nettype wire

FILE: rtl/grs_front.sv
// Input front: accepts items, classifies them and squares the pixel values.
`timescale 1ns / 1ps
`default_nettype none
module grs_front #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_DIM      = 1024
) (
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_cmd,
    input  wire logic [grs_pkg::LABEL_W-1:0]  i_segment_label,
    input  wire logic [grs_pkg::GRAY_W-1:0]   i_gray_level,
    input  wire logic [grs_pkg::COORD_W-1:0]  i_pixel_row,
    input  wire logic [grs_pkg::COORD_W-1:0]  i_pixel_col,
    input  wire logic                         i_q_full,
    input  wire logic                         i_clr_done,
    output logic                              o_push,
    output grs_pkg::t_op                      o_op
);

    logic                          oor;
    logic [grs_pkg::COORD_W-1:0]   row_s;
    logic [grs_pkg::COORD_W-1:0]   col_s;

    // Flag labels beyond the store and clamp coordinates
    assign oor   = 32'(i_segment_label) >= 32'(MAX_SEGMENTS);
    assign row_s = (32'(i_pixel_row) >= 32'(MAX_DIM)) ?
                   grs_pkg::COORD_W'(MAX_DIM - 1) : i_pixel_row;
    assign col_s = (32'(i_pixel_col) >= 32'(MAX_DIM)) ?
                   grs_pkg::COORD_W'(MAX_DIM - 1) : i_pixel_col;

    assign o_ready = !i_q_full && i_clr_done;

    // Drop accumulates for labels outside the store
    assign o_push = i_valid && o_ready && !(i_cmd == grs_pkg::CMD_ACCUM && oor);

    always_comb begin
        o_op.is_read = (i_cmd == grs_pkg::CMD_READ);
        o_op.oor     = oor;
        o_op.label   = i_segment_label;
        o_op.gray    = i_gray_level;
        o_op.gray_sq = i_gray_level * i_gray_level;
        o_op.row     = row_s;
        o_op.row_sq  = row_s * row_s;
        o_op.col     = col_s;
        o_op.col_sq  = col_s * col_s;
    end

endmodule
`default_nettype wire

FILE: rtl/grs_queue.sv
// Short queue of classified items between the front and the store.
`timescale 1ns / 1ps
`default_nettype none
module grs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  grs_pkg::t_op       i_op,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output grs_pkg::t_op       o_op
);

    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    grs_pkg::t_op   r_q [QD];
    logic [QW-1:0]  r_wr;
    logic [QW-1:0]  r_rd;
    logic [QW:0]    r_cnt;

    assign o_full  = (r_cnt == (QW+1)'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_q[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Hold item payloads
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_op;
    end

endmodule
`default_nettype wire

FILE: rtl/grs_store.sv
// Back end store: per-segment accumulators with read-modify-write and read-out.
`timescale 1ns / 1ps
`default_nettype none
module grs_store #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  grs_pkg::t_op       i_q_op,
    output logic               o_pop,
    input  wire logic          i_busy,
    output logic               o_clr_done,
    output logic               o_start,
    output grs_pkg::t_job      o_job
);

    localparam int LDEPTH = 1 << grs_pkg::LABEL_W;
    localparam int DEPTH  = (MAX_SEGMENTS < LDEPTH) ? MAX_SEGMENTS : LDEPTH;
    localparam int AW     = $clog2(DEPTH);

    grs_pkg::t_entry r_mem [DEPTH];
    grs_pkg::t_entry r_rd;
    grs_pkg::t_entry r_fwd;
    grs_pkg::t_op    r_s1;
    logic            r_s1_valid;
    logic            r_fwd_hit;
    logic            r_clr_active;
    logic [AW-1:0]   r_clr_addr;

    grs_pkg::t_entry base;
    grs_pkg::t_entry n_acc;
    grs_pkg::t_entry wdata;
    grs_pkg::t_entry wd;
    logic            s1_write;
    logic            we;
    logic [AW-1:0]   waddr;

    // Take the entry just written when the same segment follows directly
    assign base     = r_fwd_hit ? r_fwd : r_rd;
    assign s1_write = r_s1_valid && !(r_s1.is_read && r_s1.oor);

    always_comb begin
        n_acc.gray_sum    = base.gray_sum + grs_pkg::GSUM_W'(r_s1.gray);
        n_acc.gray_sq_sum = base.gray_sq_sum + grs_pkg::GSQ_W'(r_s1.gray_sq);
        n_acc.row_sum     = base.row_sum + grs_pkg::CSUM_W'(r_s1.row);
        n_acc.col_sum     = base.col_sum + grs_pkg::CSUM_W'(r_s1.col);
        n_acc.row_sq_sum  = base.row_sq_sum + grs_pkg::CSQ_W'(r_s1.row_sq);
        n_acc.col_sq_sum  = base.col_sq_sum + grs_pkg::CSQ_W'(r_s1.col_sq);
        n_acc.count       = base.count + 1'b1;
    end

    // A read clears the entry it reports
    assign wdata = r_s1.is_read ? '0 : n_acc;
    assign we    = r_clr_active || s1_write;
    assign waddr = r_clr_active ? r_clr_addr : r_s1.label[AW-1:0];
    assign wd    = r_clr_active ? '0 : wdata;

    assign o_pop      = i_q_valid && !r_clr_active && !i_busy &&
                        !(r_s1_valid && r_s1.is_read);
    assign o_clr_done = !r_clr_active;
    assign o_start    = r_s1_valid && r_s1.is_read;

    always_comb begin
        o_job.oor   = r_s1.oor;
        o_job.label = r_s1.label;
        o_job.ent   = base;
    end

    // Memory port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wd;
        if (o_pop) r_rd <= r_mem[i_q_op.label[AW-1:0]];
    end

    // Sweep the store after reset, then track the pipeline stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd_hit    <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) r_clr_active <= 1'b0;
            end
            r_s1_valid <= o_pop;
            r_fwd_hit  <= o_pop && s1_write &&
                          (r_s1.label[AW-1:0] == i_q_op.label[AW-1:0]);
        end
    end

    // Hold stage payloads
    always_ff @(posedge i_clk) begin
        if (o_pop) r_s1 <= i_q_op;
        r_fwd <= wdata;
    end

endmodule
`default_nettype wire

FILE: rtl/grs_moments.sv
// Read-out unit: means and standard deviations with a shared multiplier,
// divider and square root.
`timescale 1ns / 1ps
`default_nettype none
module grs_moments (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  grs_pkg::t_job                      i_job,
    output logic                               o_busy,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [grs_pkg::LABEL_W-1:0]        o_segment_index,
    output logic [grs_pkg::MEANG_W-1:0]        o_mean_gray,
    output logic [grs_pkg::STDG_W-1:0]         o_std_gray,
    output logic [grs_pkg::MEANC_W-1:0]        o_centroid_row,
    output logic [grs_pkg::MEANC_W-1:0]        o_centroid_col,
    output logic [grs_pkg::STDC_W-1:0]         o_std_row,
    output logic [grs_pkg::STDC_W-1:0]         o_std_col,
    output logic [grs_pkg::CNT_W-1:0]          o_pixel_count
);

    localparam int NUM_W = 77;
    localparam int DEN_W = 42;
    localparam int DIV_N = NUM_W;
    localparam int SQ_W  = 48;
    localparam int SQ_N  = SQ_W / 2;
    localparam int RT_W  = SQ_W / 2;
    localparam int SR_W  = RT_W + 2;

    localparam logic [1:0] MOM_GRAY = 2'd0;
    localparam logic [1:0] MOM_ROW  = 2'd1;
    localparam logic [1:0] MOM_COL  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_DIFF = 7'b0000100,
        ST_DIVM = 7'b0001000,
        ST_DIVV = 7'b0010000,
        ST_SQRT = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state                       r_state;
    logic [1:0]                   r_k;
    logic [1:0]                   r_step;
    logic [6:0]                   r_dcnt;
    logic [4:0]                   r_scnt;
    logic                         r_ovalid;

    grs_pkg::t_job                r_job;
    logic [grs_pkg::CNT_W-1:0]    r_n;
    logic [59:0]                  r_prod;
    logic [60:0]                  r_a;
    logic [59:0]                  r_b;
    logic [60:0]                  r_d;
    logic [DEN_W-1:0]             r_n2;
    logic [NUM_W-1:0]             r_dnum;
    logic [DEN_W-1:0]             r_dden;
    logic [DEN_W-1:0]             r_drem;
    logic [NUM_W-1:0]             r_dq;
    logic [SQ_W-1:0]              r_sx;
    logic [SR_W-1:0]              r_srem;
    logic [RT_W-1:0]              r_sroot;

    logic [grs_pkg::MEANG_W-1:0]  r_mean_g;
    logic [grs_pkg::STDG_W-1:0]   r_std_g;
    logic [grs_pkg::MEANC_W-1:0]  r_mean_r;
    logic [grs_pkg::MEANC_W-1:0]  r_mean_c;
    logic [grs_pkg::STDC_W-1:0]   r_std_r;
    logic [grs_pkg::STDC_W-1:0]   r_std_c;

    logic [grs_pkg::LABEL_W-1:0]  r_o_idx;
    logic [grs_pkg::MEANG_W-1:0]  r_o_mean_g;
    logic [grs_pkg::STDG_W-1:0]   r_o_std_g;
    logic [grs_pkg::MEANC_W-1:0]  r_o_mean_r;
    logic [grs_pkg::MEANC_W-1:0]  r_o_mean_c;
    logic [grs_pkg::STDC_W-1:0]   r_o_std_r;
    logic [grs_pkg::STDC_W-1:0]   r_o_std_c;
    logic [grs_pkg::CNT_W-1:0]    r_o_cnt;

    logic [29:0]                  s1;
    logic [39:0]                  s2;
    logic                         is_gray;
    logic [29:0]                  mul_a;
    logic [29:0]                  mul_b;
    logic [59:0]                  prod;
    logic [DEN_W:0]               rem_sh;
    logic [DEN_W:0]               rem_sub;
    logic                         dge;
    logic [DEN_W-1:0]             n_drem;
    logic [NUM_W-1:0]             n_dq;
    logic [SR_W+1:0]              srem_sh;
    logic [SR_W+1:0]              trial;
    logic [SR_W+1:0]              sdiff;
    logic                         sge;
    logic [SR_W-1:0]              n_srem;
    logic [RT_W-1:0]              n_sroot;
    logic [SQ_W-1:0]              vclamp;
    logic [NUM_W-1:0]             mean_num;
    logic [NUM_W-1:0]             var_num;
    logic                         out_free;

    // Select the sums of the moment in progress
    always_comb begin
        case (r_k)
            MOM_GRAY: begin
                s1 = 30'(r_job.ent.gray_sum);
                s2 = 40'(r_job.ent.gray_sq_sum);
            end
            MOM_ROW: begin
                s1 = r_job.ent.row_sum;
                s2 = r_job.ent.row_sq_sum;
            end
            default: begin
                s1 = r_job.ent.col_sum;
                s2 = r_job.ent.col_sq_sum;
            end
        endcase
    end
    assign is_gray = (r_k == MOM_GRAY);

    // Shared multiplier: n*s2 in two halves, s1*s1, n*n
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = 30'(r_n);
                mul_b = 30'(s2[19:0]);
            end
            2'd1: begin
                mul_a = 30'(r_n);
                mul_b = 30'(s2[39:20]);
            end
            2'd2: begin
                mul_a = s1;
                mul_b = s1;
            end
            default: begin
                mul_a = 30'(r_n);
                mul_b = 30'(r_n);
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Restoring divider, one quotient bit a cycle
    assign rem_sh  = {r_drem, r_dnum[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dden};
    assign dge     = (rem_sh >= {1'b0, r_dden});
    assign n_drem  = dge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    assign n_dq    = {r_dq[NUM_W-2:0], dge};

    // Digit-by-digit square root, one root bit a cycle
    assign srem_sh = {r_srem, r_sx[SQ_W-1:SQ_W-2]};
    assign trial   = {2'b00, r_sroot, 2'b01};
    assign sdiff   = srem_sh - trial;
    assign sge     = (srem_sh >= trial);
    assign n_srem  = sge ? sdiff[SR_W-1:0] : srem_sh[SR_W-1:0];
    assign n_sroot = {r_sroot[RT_W-2:0], sge};

    // Scaled numerators; a variance too large for the root saturates
    assign mean_num = is_gray ? (NUM_W'(s1) << 8) : (NUM_W'(s1) << 4);
    assign var_num  = is_gray ? (NUM_W'(r_d) << 16) : (NUM_W'(r_d) << 8);
    assign vclamp   = (n_dq[NUM_W-1:SQ_W] != '0) ? '1 : n_dq[SQ_W-1:0];

    assign out_free = !r_ovalid || i_ready;
    assign o_busy   = (r_state != ST_IDLE);

    // Sequence the three moments
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= MOM_GRAY;
            r_step   <= '0;
            r_dcnt   <= '0;
            r_scnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_k    <= MOM_GRAY;
                        r_step <= '0;
                        if (i_job.oor || i_job.ent.count == '0) r_state <= ST_OUT;
                        else r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_dcnt  <= '0;
                    r_state <= ST_DIVM;
                end
                ST_DIVM: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 7'(DIV_N - 1)) begin
                        r_dcnt  <= '0;
                        r_state <= ST_DIVV;
                    end
                end
                ST_DIVV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 7'(DIV_N - 1)) begin
                        r_scnt  <= '0;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == 5'(SQ_N - 1)) begin
                        r_step <= '0;
                        if (r_k == MOM_COL) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_job    <= i_job;
                    r_n      <= i_job.oor ? '0 : i_job.ent.count;
                    r_mean_g <= '0;
                    r_std_g  <= '0;
                    r_mean_r <= '0;
                    r_mean_c <= '0;
                    r_std_r  <= '0;
                    r_std_c  <= '0;
                end
            end
            ST_MUL: begin
                r_prod <= prod;
                case (r_step)
                    2'd1:    r_a <= 61'(r_prod[40:0]);
                    2'd2:    r_a <= r_a + {r_prod[40:0], 20'd0};
                    2'd3:    r_b <= r_prod;
                    default: r_a <= r_a;
                endcase
            end
            ST_DIFF: begin
                r_n2   <= r_prod[DEN_W-1:0];
                r_d    <= (r_a >= {1'b0, r_b}) ? (r_a - {1'b0, r_b}) : ({1'b0, r_b} - r_a);
                r_dnum <= mean_num;
                r_dden <= DEN_W'(r_n);
                r_drem <= '0;
                r_dq   <= '0;
            end
            ST_DIVM: begin
                r_dnum <= r_dnum << 1;
                r_drem <= n_drem;
                r_dq   <= n_dq;
                if (r_dcnt == 7'(DIV_N - 1)) begin
                    // Store the clamped mean, then load the variance division
                    case (r_k)
                        MOM_GRAY: r_mean_g <= (n_dq > NUM_W'(grs_pkg::MEAN_MAX_GRAY)) ?
                            grs_pkg::MEANG_W'(grs_pkg::MEAN_MAX_GRAY) :
                            n_dq[grs_pkg::MEANG_W-1:0];
                        MOM_ROW:  r_mean_r <= (n_dq > NUM_W'(grs_pkg::MEAN_MAX_COORD)) ?
                            grs_pkg::MEANC_W'(grs_pkg::MEAN_MAX_COORD) :
                            n_dq[grs_pkg::MEANC_W-1:0];
                        default:  r_mean_c <= (n_dq > NUM_W'(grs_pkg::MEAN_MAX_COORD)) ?
                            grs_pkg::MEANC_W'(grs_pkg::MEAN_MAX_COORD) :
                            n_dq[grs_pkg::MEANC_W-1:0];
                    endcase
                    r_dnum <= var_num;
                    r_dden <= r_n2;
                    r_drem <= '0;
                    r_dq   <= '0;
                end
            end
            ST_DIVV: begin
                r_dnum <= r_dnum << 1;
                r_drem <= n_drem;
                r_dq   <= n_dq;
                if (r_dcnt == 7'(DIV_N - 1)) begin
                    r_sx    <= vclamp;
                    r_srem  <= '0;
                    r_sroot <= '0;
                end
            end
            ST_SQRT: begin
                r_sx    <= r_sx << 2;
                r_srem  <= n_srem;
                r_sroot <= n_sroot;
                if (r_scnt == 5'(SQ_N - 1)) begin
                    // Store the clamped standard deviation
                    case (r_k)
                        MOM_GRAY: r_std_g <= (n_sroot > RT_W'(grs_pkg::STD_MAX_GRAY)) ?
                            grs_pkg::STDG_W'(grs_pkg::STD_MAX_GRAY) :
                            n_sroot[grs_pkg::STDG_W-1:0];
                        MOM_ROW:  r_std_r <= (n_sroot > RT_W'(grs_pkg::STD_MAX_COORD)) ?
                            grs_pkg::STDC_W'(grs_pkg::STD_MAX_COORD) :
                            n_sroot[grs_pkg::STDC_W-1:0];
                        default:  r_std_c <= (n_sroot > RT_W'(grs_pkg::STD_MAX_COORD)) ?
                            grs_pkg::STDC_W'(grs_pkg::STD_MAX_COORD) :
                            n_sroot[grs_pkg::STDC_W-1:0];
                    endcase
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_o_idx    <= r_job.label;
                    r_o_mean_g <= r_mean_g;
                    r_o_std_g  <= r_std_g;
                    r_o_mean_r <= r_mean_r;
                    r_o_mean_c <= r_mean_c;
                    r_o_std_r  <= r_std_r;
                    r_o_std_c  <= r_std_c;
                    r_o_cnt    <= r_n;
                end
            end
            default: r_prod <= r_prod;
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_segment_index = r_o_idx;
    assign o_mean_gray     = r_o_mean_g;
    assign o_std_gray      = r_o_std_g;
    assign o_centroid_row  = r_o_mean_r;
    assign o_centroid_col  = r_o_mean_c;
    assign o_std_row       = r_o_std_r;
    assign o_std_col       = r_o_std_c;
    assign o_pixel_count   = r_o_cnt;

endmodule
`default_nettype wire

FILE: rtl/gray_region_statistics.sv
// Top level: per-segment gray and position statistics with read and clear.
//
//   channel  | valid   | ready   | payload
//   ---------+---------+---------+---------------------------------------------
//   input    | i_valid | o_ready | i_cmd, i_segment_label, i_gray_level,
//            |         |         | i_pixel_row, i_pixel_col
//   output   | o_valid | i_ready | o_segment_index, o_mean_gray, o_std_gray,
//            |         |         | o_centroid_row/col, o_std_row/col, o_pixel_count
//
// Accumulate items are taken one per cycle while o_ready is high; the store does
// a read-modify-write through a registered read and a write stage, with forwarding
// for back-to-back hits on one segment. A read item occupies the moments unit for
// three moments, each four multiplier steps, two divisions and a root. After reset
// the store is swept, one entry a cycle, over all min(MAX_SEGMENTS, 1024) entries,
// with o_ready low. The store pauses while a read-out runs, so the four-entry
// queue takes at most four more items before o_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module gray_region_statistics #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_DIM      = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_cmd,
    input  wire logic [grs_pkg::LABEL_W-1:0]   i_segment_label,
    input  wire logic [grs_pkg::GRAY_W-1:0]    i_gray_level,
    input  wire logic [grs_pkg::COORD_W-1:0]   i_pixel_row,
    input  wire logic [grs_pkg::COORD_W-1:0]   i_pixel_col,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [grs_pkg::LABEL_W-1:0]        o_segment_index,
    output logic [grs_pkg::MEANG_W-1:0]        o_mean_gray,
    output logic [grs_pkg::STDG_W-1:0]         o_std_gray,
    output logic [grs_pkg::MEANC_W-1:0]        o_centroid_row,
    output logic [grs_pkg::MEANC_W-1:0]        o_centroid_col,
    output logic [grs_pkg::STDC_W-1:0]         o_std_row,
    output logic [grs_pkg::STDC_W-1:0]         o_std_col,
    output logic [grs_pkg::CNT_W-1:0]          o_pixel_count
);

    logic           w_push;
    grs_pkg::t_op   w_op_in;
    logic           w_q_full;
    logic           w_q_valid;
    grs_pkg::t_op   w_q_op;
    logic           w_pop;
    logic           w_busy;
    logic           w_clr_done;
    logic           w_start;
    grs_pkg::t_job  w_job;

    // Classify incoming items
    grs_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_DIM      (MAX_DIM)
    ) u_front (
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_segment_label (i_segment_label),
        .i_gray_level    (i_gray_level),
        .i_pixel_row     (i_pixel_row),
        .i_pixel_col     (i_pixel_col),
        .i_q_full        (w_q_full),
        .i_clr_done      (w_clr_done),
        .o_push          (w_push),
        .o_op            (w_op_in)
    );

    // Decouple front and back
    grs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_op    (w_q_op)
    );

    // Accumulate into the segment store
    grs_store #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_op     (w_q_op),
        .o_pop      (w_pop),
        .i_busy     (w_busy),
        .o_clr_done (w_clr_done),
        .o_start    (w_start),
        .o_job      (w_job)
    );

    // Compute statistics for read items
    grs_moments u_moments (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_start),
        .i_job           (w_job),
        .o_busy          (w_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_segment_index (o_segment_index),
        .o_mean_gray     (o_mean_gray),
        .o_std_gray      (o_std_gray),
        .o_centroid_row  (o_centroid_row),
        .o_centroid_col  (o_centroid_col),
        .o_std_row       (o_std_row),
        .o_std_col       (o_std_col),
        .o_pixel_count   (o_pixel_count)
    );

    // A read-out never starts while the moments unit is occupied
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_start)
        else $error("read-out started while moments unit busy");

    // An empty segment reports zero statistics
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_count == '0) |->
        (o_mean_gray == '0 && o_std_gray == '0 && o_centroid_row == '0 &&
         o_centroid_col == '0 && o_std_row == '0 && o_std_col == '0))
        else $error("empty segment with nonzero statistics");

    // A single pixel has no spread
    a_single_no_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_count == grs_pkg::CNT_W'(1)) |->
        (o_std_gray == '0 && o_std_row == '0 && o_std_col == '0))
        else $error("single-pixel segment with nonzero deviation");

    // Means stay within their saturation limits
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
        (o_mean_gray <= grs_pkg::MEANG_W'(grs_pkg::MEAN_MAX_GRAY) &&
         o_centroid_row <= grs_pkg::MEANC_W'(grs_pkg::MEAN_MAX_COORD) &&
         o_centroid_col <= grs_pkg::MEANC_W'(grs_pkg::MEAN_MAX_COORD)))
        else $error("mean beyond saturation limit");

endmodule
`default_nettype wire
